@@ hw/rtl/crpf_pkg.sv @@
// ----------------------------------------------------------------------------
// Catmull-Rom path follower package
// Shared request, response, command and status types, register indexes and
// fixed-point widths of the path follower.
// ----------------------------------------------------------------------------
package crpf_pkg;

   // Coordinate and fraction widths (Q16.16 coordinates, Q0.16 path time).
   localparam int COORD_W = 32;
   localparam int FRAC_W  = 16;

   // Datapath widths: point plus base, doubled basis weight, product, sum.
   localparam int PSUM_W = COORD_W + 1;
   localparam int WGT_W  = 20;
   localparam int PROD_W = PSUM_W + WGT_W;
   localparam int ACC_W  = PROD_W + 2;

   // Number of axes and control points that one segment spans.
   localparam int NUM_AXES   = 3;
   localparam int SEG_POINTS = 4;

   // Constant term of the second weight (2.0 in Q4.16) and rounding bias.
   localparam logic signed [WGT_W-1:0] W1_BIAS    = 20'sd131072;
   localparam logic signed [ACC_W-1:0] ROUND_BIAS = 55'sd65536;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int NUMPTS_W   = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_ANIMATE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_POINTS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_X     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_Y     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_Z     = 3'd4;

   // Request kinds.
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // Request payload.
   typedef struct packed {
      logic                      kind;
      logic [5:0]                point_index;
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
      logic [FRAC_W-1:0]         time_step;
   } req_type;

   // Response payload.
   typedef struct packed {
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_z;
      logic                      moving;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load_wr;     // write the request's point into the table
      logic       take_tick;   // capture the request's time step
      logic       time_update; // advance or clear the path time
      logic       sqr_en;      // fraction squared
      logic       cube_en;     // fraction cubed
      logic       wgt_en;      // basis weights
      logic       rd_en;       // table read
      logic [1:0] rd_ofs;      // point offset within the segment
      logic       sum_en;      // point plus base center
      logic       mul_en;      // weight times point
      logic [1:0] wsel;        // weight used by the multiply
      logic       acc_en;      // accumulate the product
      logic       acc_clr;     // first product of a segment
      logic       out_load;    // load the response register
      logic       out_spline;  // response comes from the spline
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic active; // animation enabled and enough points
   } sts_type;

endpackage

@@ hw/rtl/crpf_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module crpf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/crpf_dpath.sv @@
// ----------------------------------------------------------------------------
// Catmull-Rom path follower datapath
// Configuration registers, control point table, path time and the cubic
// evaluation with one multiplier per axis, driven by the controller.
// ----------------------------------------------------------------------------
module crpf_dpath #(
   parameter int MAX_POINTS = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [crpf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [crpf_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  crpf_pkg::req_type                  req_data,
   input  crpf_pkg::cmd_type                  cmd,
   output crpf_pkg::sts_type                  sts,
   output crpf_pkg::rsp_type                  rsp_data
);

   localparam int AW   = $clog2(MAX_POINTS);
   localparam int NW   = ($clog2(MAX_POINTS + 1) > crpf_pkg::NUMPTS_W) ?
                         $clog2(MAX_POINTS + 1) : crpf_pkg::NUMPTS_W;
   localparam int TW   = NW + 1;
   localparam int CW   = crpf_pkg::COORD_W;
   localparam int FW   = crpf_pkg::FRAC_W;
   localparam int NAX  = crpf_pkg::NUM_AXES;
   localparam int NSEG = crpf_pkg::SEG_POINTS;

   // Configuration registers.
   logic                           animate_ff;
   logic [crpf_pkg::NUMPTS_W-1:0]  num_points_ff;
   logic signed [CW-1:0]           base_ff [NAX];

   // Path time and captured step.
   logic [AW-1:0] seg_ff, seg_in;
   logic [FW-1:0] frac_ff, frac_in;
   logic [FW-1:0] step_ff;

   // Polynomial terms and weights.
   logic [FW-1:0]                         u2_ff, u2_in;
   logic [FW-1:0]                         u3_ff, u3_in;
   logic signed [crpf_pkg::WGT_W-1:0]     h_ff [NSEG];
   logic signed [crpf_pkg::WGT_W-1:0]     h_in [NSEG];

   // Per-axis pipeline.
   logic signed [crpf_pkg::PSUM_W-1:0] sum_ff  [NAX];
   logic signed [crpf_pkg::PSUM_W-1:0] sum_in  [NAX];
   logic signed [crpf_pkg::PROD_W-1:0] prod_ff [NAX];
   logic signed [crpf_pkg::PROD_W-1:0] prod_in [NAX];
   logic signed [crpf_pkg::ACC_W-1:0]  acc_ff  [NAX];
   logic signed [crpf_pkg::ACC_W-1:0]  acc_in  [NAX];
   logic signed [crpf_pkg::ACC_W-1:0]  rnd     [NAX];

   crpf_pkg::rsp_type rsp_ff, rsp_in;

   // Table signals.
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [NAX*CW-1:0]   wr_data;
   logic [AW-1:0]       rd_addr;
   logic [NAX*CW-1:0]   rd_data;

   // Time update signals.
   logic [NW-1:0]   np_w;
   logic [NW-1:0]   n_eff;
   logic [FW:0]     frac_sum;
   logic [TW-1:0]   nseg;
   logic [TW-1:0]   seg_inc;
   logic [TW-1:0]   seg_red;
   logic [TW-1:0]   seg_new;

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         animate_ff    <= 1'b0;
         num_points_ff <= '0;
         for (int a = 0; a < NAX; a++) begin
            base_ff[a] <= '0;
         end
      end else if (csr_write_en) begin
         unique case (csr_index)
            crpf_pkg::CSR_ANIMATE:    animate_ff    <= csr_wdata[0];
            crpf_pkg::CSR_NUM_POINTS: num_points_ff <= csr_wdata[crpf_pkg::NUMPTS_W-1:0];
            crpf_pkg::CSR_BASE_X:     base_ff[0]    <= $signed(csr_wdata[CW-1:0]);
            crpf_pkg::CSR_BASE_Y:     base_ff[1]    <= $signed(csr_wdata[CW-1:0]);
            crpf_pkg::CSR_BASE_Z:     base_ff[2]    <= $signed(csr_wdata[CW-1:0]);
            default: begin
            end
         endcase
      end
   end

   // Effective point count and the enable condition.
   always_comb begin
      np_w   = NW'(num_points_ff);
      n_eff  = (np_w > NW'(MAX_POINTS)) ? NW'(MAX_POINTS) : np_w;
      sts.active = animate_ff && (n_eff >= NW'(NSEG));
   end

   // Control point table; a load beyond the table is dropped.
   assign wr_en   = cmd.load_wr && (NW'(req_data.point_index) < NW'(MAX_POINTS));
   assign wr_addr = AW'(req_data.point_index);
   assign wr_data = {req_data.point_z, req_data.point_y, req_data.point_x};
   assign rd_addr = seg_ff + AW'(cmd.rd_ofs);

   crpf_ram #(
      .WIDTH (NAX * CW),
      .DEPTH (MAX_POINTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Path time advance with a single wrap and a restart when still out of range.
   always_comb begin
      frac_sum = {1'b0, frac_ff} + {1'b0, step_ff};
      nseg     = TW'(n_eff) - TW'(NSEG - 1);
      seg_inc  = TW'(seg_ff) + TW'(frac_sum[FW]);
      seg_red  = (seg_inc >= nseg) ? (seg_inc - nseg) : seg_inc;
      seg_new  = (seg_red >= nseg) ? '0 : seg_red;
      if (sts.active) begin
         seg_in  = seg_new[AW-1:0];
         frac_in = frac_sum[FW-1:0];
      end else begin
         seg_in  = '0;
         frac_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff  <= '0;
         frac_ff <= '0;
      end else if (cmd.time_update) begin
         seg_ff  <= seg_in;
         frac_ff <= frac_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_tick) begin
         step_ff <= req_data.time_step;
      end
   end

   // Fraction squared and cubed, truncated to Q0.16.
   logic [2*FW-1:0] sq_full;
   logic [2*FW-1:0] cube_full;

   always_comb begin
      sq_full   = frac_ff * frac_ff;
      cube_full = u2_ff * frac_ff;
      u2_in     = sq_full[2*FW-1:FW];
      u3_in     = cube_full[2*FW-1:FW];
   end

   // Doubled Catmull-Rom basis weights.
   logic signed [crpf_pkg::WGT_W-1:0] fs, u2s, u3s;

   always_comb begin
      fs    = $signed(crpf_pkg::WGT_W'(frac_ff));
      u2s   = $signed(crpf_pkg::WGT_W'(u2_ff));
      u3s   = $signed(crpf_pkg::WGT_W'(u3_ff));
      h_in[0] = (u2s <<< 1) - fs - u3s;
      h_in[1] = crpf_pkg::W1_BIAS - ((u2s <<< 2) + u2s) + ((u3s <<< 1) + u3s);
      h_in[2] = fs + (u2s <<< 2) - ((u3s <<< 1) + u3s);
      h_in[3] = u3s - u2s;
   end

   always_ff @(posedge clock) begin
      if (cmd.sqr_en) begin
         u2_ff <= u2_in;
      end
      if (cmd.cube_en) begin
         u3_ff <= u3_in;
      end
      if (cmd.wgt_en) begin
         for (int i = 0; i < NSEG; i++) begin
            h_ff[i] <= h_in[i];
         end
      end
   end

   // Per-axis point sum, weighted product, accumulation and rounding.
   always_comb begin
      for (int a = 0; a < NAX; a++) begin
         sum_in[a]  = crpf_pkg::PSUM_W'($signed(rd_data[a*CW +: CW])) +
                      crpf_pkg::PSUM_W'(base_ff[a]);
         prod_in[a] = sum_ff[a] * h_ff[cmd.wsel];
         if (cmd.acc_clr) begin
            acc_in[a] = crpf_pkg::ACC_W'(prod_ff[a]);
         end else begin
            acc_in[a] = acc_ff[a] + crpf_pkg::ACC_W'(prod_ff[a]);
         end
         rnd[a] = acc_ff[a] + crpf_pkg::ROUND_BIAS;
      end
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < NAX; a++) begin
         if (cmd.sum_en) begin
            sum_ff[a] <= sum_in[a];
         end
         if (cmd.mul_en) begin
            prod_ff[a] <= prod_in[a];
         end
         if (cmd.acc_en) begin
            acc_ff[a] <= acc_in[a];
         end
      end
   end

   // Response register: spline position or the base center.
   always_comb begin
      if (cmd.out_spline) begin
         rsp_in.pos_x = rnd[0][FW+CW:FW+1];
         rsp_in.pos_y = rnd[1][FW+CW:FW+1];
         rsp_in.pos_z = rnd[2][FW+CW:FW+1];
      end else begin
         rsp_in.pos_x = base_ff[0];
         rsp_in.pos_y = base_ff[1];
         rsp_in.pos_z = base_ff[2];
      end
      rsp_in.moving = cmd.out_spline;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

@@ hw/rtl/crpf_ctrl.sv @@
// ----------------------------------------------------------------------------
// Catmull-Rom path follower controller
// Sequences request intake, time update, weight computation, the four-point
// multiply-accumulate pipeline and the response handshake.
// ----------------------------------------------------------------------------
module crpf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_kind,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  crpf_pkg::sts_type sts,
   output crpf_pkg::cmd_type cmd
);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_TIME = 7'b0000010,
      ST_SQR  = 7'b0000100,
      ST_CUBE = 7'b0001000,
      ST_WGT  = 7'b0010000,
      ST_MAC  = 7'b0100000,
      ST_OUT  = 7'b1000000
   } state_type;

   // Step counter points of the multiply-accumulate pipeline.
   localparam logic [2:0] MAC_RD_LAST  = 3'd3;
   localparam logic [2:0] MAC_SUM_LAST = 3'd4;
   localparam logic [2:0] MAC_MUL_LAST = 3'd5;
   localparam logic [2:0] MAC_ACC_FIRST = 3'd3;
   localparam logic [2:0] MAC_LAST     = 3'd6;
   localparam logic [2:0] MAC_SUM_FIRST = 3'd1;
   localparam logic [2:0] MAC_MUL_FIRST = 3'd2;

   state_type  state_ff, state_in;
   logic [2:0] cnt_ff, cnt_in;
   logic [2:0] wsel_full;
   logic       spline_ff, spline_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign wsel_full = cnt_ff - MAC_MUL_FIRST;

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      spline_in    = spline_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.out_spline = spline_ff;
      cmd.rd_ofs   = cnt_ff[1:0];
      cmd.wsel     = wsel_full[1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_kind == crpf_pkg::KIND_TICK) begin
                  cmd.take_tick = 1'b1;
                  state_in      = ST_TIME;
               end else begin
                  cmd.load_wr = 1'b1;
               end
            end
         end
         ST_TIME: begin
            cmd.time_update = 1'b1;
            spline_in       = sts.active;
            state_in        = sts.active ? ST_SQR : ST_OUT;
         end
         ST_SQR: begin
            cmd.sqr_en = 1'b1;
            state_in   = ST_CUBE;
         end
         ST_CUBE: begin
            cmd.cube_en = 1'b1;
            state_in    = ST_WGT;
         end
         ST_WGT: begin
            cmd.wgt_en = 1'b1;
            cnt_in     = '0;
            state_in   = ST_MAC;
         end
         ST_MAC: begin
            // Read, add base, multiply and accumulate overlap by one step each.
            cmd.rd_en   = (cnt_ff <= MAC_RD_LAST);
            cmd.sum_en  = (cnt_ff >= MAC_SUM_FIRST) && (cnt_ff <= MAC_SUM_LAST);
            cmd.mul_en  = (cnt_ff >= MAC_MUL_FIRST) && (cnt_ff <= MAC_MUL_LAST);
            cmd.acc_en  = (cnt_ff >= MAC_ACC_FIRST);
            cmd.acc_clr = (cnt_ff == MAC_ACC_FIRST);
            if (cnt_ff == MAC_LAST) begin
               state_in = ST_OUT;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         spline_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         spline_ff    <= spline_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ hw/rtl/catmull_rom_path_follower.sv @@
// Timing: along the spline a tick request passes the time update, squaring,
// cubing, weight and four-point multiply-accumulate steps before its response
// is loaded; held at the base center, the response follows the time update.
// Requests wait until that response is loaded; one load per cycle while idle.
// Reset: synchronous, active high; clears configuration, path time and
// handshake state. The control point table is not cleared.
// ----------------------------------------------------------------------------
// Catmull-Rom path follower
// Keeps a table of 3-D control points and a path time, and on each tick
// request returns the uniform Catmull-Rom position offset by the base center.
// ----------------------------------------------------------------------------
module catmull_rom_path_follower #(
   parameter int MAX_POINTS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [crpf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [crpf_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  crpf_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output crpf_pkg::rsp_type               rsp_data
);

   crpf_pkg::cmd_type cmd;
   crpf_pkg::sts_type sts;

   // Controller.
   crpf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.kind),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath.
   crpf_dpath #(
      .MAX_POINTS (MAX_POINTS)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_data     (req_data),
      .cmd          (cmd),
      .sts          (sts),
      .rsp_data     (rsp_data)
   );

endmodule
